// ----- rtl/prlm_pkg.sv -----
package prlm_pkg;

   localparam int PATTERN_MAX_LEN = 8;
   localparam int PATTERN_SLOTS   = 4;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [2:0] ST_MATCHED    = 3'd0;
   localparam logic [2:0] ST_SHORT      = 3'd1;
   localparam logic [2:0] ST_NOT_POST   = 3'd2;
   localparam logic [2:0] ST_NO_SLASH   = 3'd3;
   localparam logic [2:0] ST_NO_HTTP    = 3'd4;
   localparam logic [2:0] ST_NO_PATTERN = 3'd5;

   localparam logic [2:0] CSR_PATTERN_TEXT_0  = 3'd0;
   localparam logic [2:0] CSR_PATTERN_TEXT_1  = 3'd1;
   localparam logic [2:0] CSR_PATTERN_TEXT_2  = 3'd2;
   localparam logic [2:0] CSR_PATTERN_TEXT_3  = 3'd3;
   localparam logic [2:0] CSR_PATTERN_LENGTHS = 3'd4;
   localparam logic [2:0] CSR_PATTERN_COUNT   = 3'd5;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic [7:0] request_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [1:0] matched_index;
   } rsp_type;

   typedef struct packed {
      logic [PATTERN_SLOTS-1:0][63:0] pattern_text;
      logic [15:0]                    pattern_lengths;
      logic [2:0]                     pattern_count;
   } cfg_type;

   typedef struct packed {
      logic       path_vld;
      logic [7:0] path_byte;
      logic       last;
      logic [2:0] status;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } fifo_status_type;

endpackage

// ----- rtl/post_request_line_matcher_top.sv -----
// Request-line matcher for POST requests.
// req_ channel: one request byte per transaction, last_byte marks the end of
// a request. rsp_ channel: one status transaction per request, after its
// final byte; matched_index is 0 unless status is matched.
// csr_ channel: register writes (index, data), always ready; write only while
// no request is in flight.
// Throughput: one byte per cycle unless req_stall is high. The front end
// tracks the POST prefix and the four-byte HTTP/ window; path bytes and the
// final verdict pass through a four-entry queue to the back end, which runs
// the pattern compare and drives the output register.
// Result path: with the queue empty, the final byte's entry is written into
// the queue, then popped into the output register that drives rsp_valid.
// Stall: while rsp_stall holds a result, path transactions keep draining; the
// next final transaction waits at the queue head, and once the queue holds
// four entries req_stall rises.
// Reset (synchronous): parse state, queue and output clear; all pattern
// registers return to zero. No clearing pass is needed.
module post_request_line_matcher_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  prlm_pkg::req_type  req_payload,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output prlm_pkg::rsp_type  rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   prlm_pkg::cfg_type         cfg_ff, cfg_in;
   prlm_pkg::fifo_status_type q_status;
   prlm_pkg::qentry_type      push_data, head_data;
   logic                      push_valid, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            prlm_pkg::CSR_PATTERN_TEXT_0:  cfg_in.pattern_text[0] = csr_wdata;
            prlm_pkg::CSR_PATTERN_TEXT_1:  cfg_in.pattern_text[1] = csr_wdata;
            prlm_pkg::CSR_PATTERN_TEXT_2:  cfg_in.pattern_text[2] = csr_wdata;
            prlm_pkg::CSR_PATTERN_TEXT_3:  cfg_in.pattern_text[3] = csr_wdata;
            prlm_pkg::CSR_PATTERN_LENGTHS: cfg_in.pattern_lengths = csr_wdata[15:0];
            prlm_pkg::CSR_PATTERN_COUNT:   cfg_in.pattern_count = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   prlm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   prlm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .q_status   (q_status),
      .head_data  (head_data)
   );

   prlm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != prlm_pkg::ST_MATCHED
      |-> rsp_payload.matched_index == 2'd0)
      else $error("matched_index set without a match");

   a_idx_in_use: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == prlm_pkg::ST_MATCHED
      |-> {1'b0, rsp_payload.matched_index} < cfg_ff.pattern_count)
      else $error("matched slot beyond pattern count");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= prlm_pkg::ST_NO_PATTERN)
      else $error("status code out of range");

   a_final_pop: assert property (@(posedge clock) disable iff (reset)
      pop && head_data.last |=> rsp_valid)
      else $error("final transaction popped without a result");
`endif

endmodule

// ----- rtl/prlm_front.sv -----
module prlm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  prlm_pkg::req_type         req_payload,
   output logic                      req_stall,
   input  prlm_pkg::fifo_status_type q_status,
   output logic                      push_valid,
   output prlm_pkg::qentry_type      push_data
);

   localparam logic [2:0] PH_POST     = 3'd0;
   localparam logic [2:0] PH_SPACES   = 3'd1;
   localparam logic [2:0] PH_SEARCH   = 3'd2;
   localparam logic [2:0] PH_FOUND    = 3'd3;
   localparam logic [2:0] PH_NOT_POST = 3'd4;
   localparam logic [2:0] PH_NO_SLASH = 3'd5;

   logic [2:0]      phase_ff, phase_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic [2:0]      fill_ff, fill_in;
   logic [3:0][7:0] win_ff, win_in;
   logic            accept;
   logic [7:0]      b;
   logic            path_vld;
   logic [2:0]      status;

   function automatic logic [7:0] post_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = 8'h50;
         2'd1:    c = 8'h4F;
         2'd2:    c = 8'h53;
         default: c = 8'h54;
      endcase
      return c;
   endfunction

   function automatic logic is_http(input logic [3:0][7:0] w);
      return ((w[0] | 8'h20) == 8'h68) && ((w[1] | 8'h20) == 8'h74) &&
             ((w[2] | 8'h20) == 8'h74) && ((w[3] | 8'h20) == 8'h70);
   endfunction

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign b         = req_payload.request_byte;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      fill_in  = fill_ff;
      win_in   = win_ff;
      path_vld = 1'b0;
      status   = prlm_pkg::ST_SHORT;
      if (accept) begin
         unique case (phase_ff)
            PH_POST: begin
               if (cnt_ff < 4'd4 && b != post_char(cnt_ff[1:0])) begin
                  phase_in = PH_NOT_POST;
               end else if (cnt_ff >= 4'd3) begin
                  phase_in = PH_SPACES;
               end
            end
            PH_SPACES: begin
               if (b == prlm_pkg::CHAR_SLASH) begin
                  phase_in = PH_SEARCH;
               end else if (b != prlm_pkg::CHAR_SPACE) begin
                  phase_in = PH_NO_SLASH;
               end
            end
            PH_SEARCH: begin
               if (fill_ff >= 3'd4) begin
                  if (b == prlm_pkg::CHAR_SLASH && is_http(win_ff)) begin
                     phase_in = PH_FOUND;
                  end else begin
                     path_vld = 1'b1;
                     win_in   = {b, win_ff[3], win_ff[2], win_ff[1]};
                  end
               end else begin
                  win_in[fill_ff[1:0]] = b;
                  fill_in              = fill_ff + 3'd1;
               end
            end
            default: begin
            end
         endcase
         if (cnt_ff < 4'd8) begin
            cnt_in = cnt_ff + 4'd1;
         end
         if (cnt_in < 4'd8) begin
            status = prlm_pkg::ST_SHORT;
         end else if (phase_in == PH_NOT_POST || phase_in == PH_POST) begin
            status = prlm_pkg::ST_NOT_POST;
         end else if (phase_in == PH_SPACES || phase_in == PH_NO_SLASH) begin
            status = prlm_pkg::ST_NO_SLASH;
         end else if (phase_in == PH_SEARCH) begin
            status = prlm_pkg::ST_NO_HTTP;
         end else begin
            status = prlm_pkg::ST_NO_PATTERN;
         end
         if (req_payload.last_byte) begin
            phase_in = PH_POST;
            cnt_in   = 4'd0;
            fill_in  = 3'd0;
         end
      end
   end

   assign push_valid          = accept && (path_vld || req_payload.last_byte);
   assign push_data.path_vld  = path_vld;
   assign push_data.path_byte = win_ff[0];
   assign push_data.last      = req_payload.last_byte;
   assign push_data.status    = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_POST;
         cnt_ff   <= 4'd0;
         fill_ff  <= 3'd0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// ----- rtl/prlm_fifo.sv -----
module prlm_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  prlm_pkg::qentry_type      push_data,
   input  logic                      pop,
   output prlm_pkg::fifo_status_type q_status,
   output prlm_pkg::qentry_type      head_data
);

   localparam int PW = $clog2(prlm_pkg::QUEUE_DEPTH);

   prlm_pkg::qentry_type mem_ff [prlm_pkg::QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PW:0]          count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_status.full       = (count_ff == (PW + 1)'(prlm_pkg::QUEUE_DEPTH));
   assign q_status.head_valid = (count_ff != '0);
   assign head_data           = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop && q_status.head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/prlm_back.sv -----
module prlm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  prlm_pkg::cfg_type         cfg,
   input  prlm_pkg::fifo_status_type q_status,
   input  prlm_pkg::qentry_type      head_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output prlm_pkg::rsp_type         rsp_payload
);

   localparam int SLOTS = prlm_pkg::PATTERN_SLOTS;

   logic [3:0]         seg_len_ff, seg_len_in;
   logic [3:0]         seg_ns_ff, seg_ns_in;
   logic [SLOTS-1:0]   failed_ff, failed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   prlm_pkg::rsp_type  rsp_ff, rsp_in;
   logic [3:0]         slot_len [SLOTS];
   logic [2:0]         used;
   logic               found;
   logic [7:0]         pbyte;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_len[i] = (cfg.pattern_lengths[4*i +: 4] > 4'(prlm_pkg::PATTERN_MAX_LEN)) ?
                       4'(prlm_pkg::PATTERN_MAX_LEN) : cfg.pattern_lengths[4*i +: 4];
      end
   end

   assign used = (cfg.pattern_count > 3'(SLOTS)) ? 3'(SLOTS) : cfg.pattern_count;
   assign pop  = q_status.head_valid && (!head_data.last || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      seg_len_in   = seg_len_ff;
      seg_ns_in    = seg_ns_ff;
      failed_in    = failed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      found        = 1'b0;
      pbyte        = 8'h00;
      if (pop) begin
         if (head_data.path_vld) begin
            if (head_data.path_byte == prlm_pkg::CHAR_SLASH) begin
               seg_len_in = 4'd0;
               seg_ns_in  = 4'd0;
               failed_in  = '0;
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  pbyte = cfg.pattern_text[i][{seg_len_ff[2:0], 3'b000} +: 8];
                  if (seg_len_ff < slot_len[i] && pbyte != head_data.path_byte) begin
                     failed_in[i] = 1'b1;
                  end
               end
               if (seg_len_ff < 4'(prlm_pkg::PATTERN_MAX_LEN + 1)) begin
                  seg_len_in = seg_len_ff + 4'd1;
               end
               if (head_data.path_byte != prlm_pkg::CHAR_SPACE) begin
                  seg_ns_in = seg_len_in;
               end
            end
         end
         if (head_data.last) begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = head_data.status;
            rsp_in.matched_index = 2'd0;
            if (head_data.status == prlm_pkg::ST_NO_PATTERN) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!found && 3'(i) < used && !failed_ff[i] && slot_len[i] <= seg_ns_ff) begin
                     found                = 1'b1;
                     rsp_in.status        = prlm_pkg::ST_MATCHED;
                     rsp_in.matched_index = 2'(i);
                  end
               end
            end
            seg_len_in = 4'd0;
            seg_ns_in  = 4'd0;
            failed_in  = '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_len_ff   <= 4'd0;
         seg_ns_ff    <= 4'd0;
         failed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_len_ff   <= seg_len_in;
         seg_ns_ff    <= seg_ns_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- tb/post_request_line_matcher_top_tb.sv -----
`timescale 1ns / 1ps

module post_request_line_matcher_top_tb;
   import prlm_pkg::*;

   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PHASES          = 10;
   localparam int BYTES_PER_PHASE = 75;

   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;
   localparam logic [31:0] METHOD_WORD = "POST";

   typedef enum logic [2:0] {
      SEEK_METHOD, SKIP_SPACES, SCAN_PATH, HTTP_SEEN, BAD_METHOD, BAD_PATH
   } scan_phase_type;

   typedef enum int {SET_DIRECTED, SET_CLEAR, SET_FULL, SET_RANDOM} setting_kind_type;

   class status_scoreboard;
      logic [63:0]              pat_text [PATTERN_SLOTS];
      logic [15:0]              pat_lens;
      logic [2:0]               pat_count;
      scan_phase_type           phase;
      int                       seen;
      logic [7:0]               window [4];
      int                       window_fill;
      int                       seg_len;
      int                       seg_solid_len;
      logic [PATTERN_SLOTS-1:0] seg_miss;
      rsp_type                  pending_status [$];
      int                       failures;
      int                       status_seen [8];

      function new();
         foreach (pat_text[i]) pat_text[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
         pat_lens = '0;
         pat_count = '0;
         failures = 0;
         restart();
      endfunction

      function void restart();
         phase = SEEK_METHOD;
         seen = 0;
         foreach (window[i]) window[i] = '0;
         window_fill = 0;
         seg_len = 0;
         seg_solid_len = 0;
         seg_miss = '0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] data);
         case (idx)
            CSR_PATTERN_TEXT_0, CSR_PATTERN_TEXT_1,
            CSR_PATTERN_TEXT_2, CSR_PATTERN_TEXT_3: pat_text[idx[1:0]] = data;
            CSR_PATTERN_LENGTHS: pat_lens = data[15:0];
            CSR_PATTERN_COUNT: pat_count = data[2:0];
            default: ;
         endcase
      endfunction

      function int slot_len(int i);
         int n;
         n = int'(pat_lens[4*i +: 4]);
         return (n > PATTERN_MAX_LEN) ? PATTERN_MAX_LEN : n;
      endfunction

      function int slots_in_use();
         return (pat_count > PATTERN_SLOTS) ? PATTERN_SLOTS : int'(pat_count);
      endfunction

      function int pending();
         return pending_status.size();
      endfunction

      function void take_path_byte(logic [7:0] b);
         int i;
         if (b == CHAR_SLASH) begin
            seg_len = 0;
            seg_solid_len = 0;
            seg_miss = '0;
            return;
         end
         for (i = 0; i < PATTERN_SLOTS; i++) begin
            if (seg_len < slot_len(i) && pat_text[i][8*seg_len +: 8] != b)
               seg_miss[i] = 1'b1;
         end
         if (seg_len < PATTERN_MAX_LEN + 1)
            seg_len++;
         if (b != CHAR_SPACE)
            seg_solid_len = seg_len;
      endfunction

      function bit window_holds_http();
         return (window[0] | 8'h20) == "h" && (window[1] | 8'h20) == "t" &&
                (window[2] | 8'h20) == "t" && (window[3] | 8'h20) == "p";
      endfunction

      function void scan_byte(logic [7:0] b);
         if (window_fill < 4) begin
            window[window_fill] = b;
            window_fill++;
            return;
         end
         if (b == CHAR_SLASH && window_holds_http()) begin
            phase = HTTP_SEEN;
            return;
         end
         take_path_byte(window[0]);
         window[0] = window[1];
         window[1] = window[2];
         window[2] = window[3];
         window[3] = b;
      endfunction

      function void note_byte(req_type r);
         rsp_type v;
         int      i;
         bit      found;
         case (phase)
            SEEK_METHOD: begin
               if (seen < 4 && r.request_byte != METHOD_WORD[31-8*seen -: 8])
                  phase = BAD_METHOD;
               else if (seen >= 3)
                  phase = SKIP_SPACES;
            end
            SKIP_SPACES: begin
               if (r.request_byte == CHAR_SLASH)
                  phase = SCAN_PATH;
               else if (r.request_byte != CHAR_SPACE)
                  phase = BAD_PATH;
            end
            SCAN_PATH: scan_byte(r.request_byte);
            default: ;
         endcase
         if (seen < 8)
            seen++;
         if (!r.last_byte)
            return;
         v = '0;
         if (seen < 8) begin
            v.status = ST_SHORT;
         end else begin
            case (phase)
               SEEK_METHOD, BAD_METHOD: v.status = ST_NOT_POST;
               SKIP_SPACES, BAD_PATH: v.status = ST_NO_SLASH;
               SCAN_PATH: v.status = ST_NO_HTTP;
               default: begin
                  v.status = ST_NO_PATTERN;
                  found = 1'b0;
                  for (i = 0; i < slots_in_use(); i++) begin
                     if (!found && !seg_miss[i] && slot_len(i) <= seg_solid_len) begin
                        found = 1'b1;
                        v.status = ST_MATCHED;
                        v.matched_index = i[1:0];
                     end
                  end
               end
            endcase
         end
         pending_status.push_back(v);
         restart();
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (pending_status.size() == 0) begin
            if (failures < 10)
               $display("%0t: status %0d index %0d seen with nothing expected",
                        $time, got.status, got.matched_index);
            failures++;
            return;
         end
         want = pending_status.pop_front();
         status_seen[want.status]++;
         if (got.status !== want.status || got.matched_index !== want.matched_index) begin
            if (failures < 10)
               $display("%0t: expected status %0d index %0d, got status %0d index %0d",
                        $time, want.status, want.matched_index, got.status,
                        got.matched_index);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_payload = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   status_scoreboard status_sb = new();
   logic [7:0]       line_q [$];
   int               gap_max = 0;
   int               burst_left = 0;
   int               stall_pct = 0;
   bit               hold_request = 1'b0;
   int               bytes_sent = 0;
   int               requests_sent = 0;
   int               settings_applied = 0;

   post_request_line_matcher_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         status_sb.check_status(rsp_payload);
   end

   initial begin : rsp_side
      int run;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            run = $urandom_range(1, 8);
            rsp_stall <= ($urandom_range(99) < stall_pct);
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("No transaction for %0d cycles, giving up", quiet);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic logic [63:0] pack_text(string s);
      logic [63:0] v;
      int          k;
      v = '0;
      for (k = 0; k < s.len() && k < 8; k++)
         v[8*k +: 8] = s[k];
      return v;
   endfunction

   function automatic logic [7:0] path_char();
      string punct;
      logic [7:0] c;
      punct = "._-~=";
      case ($urandom_range(3))
         0: c = 8'("a" + $urandom_range(25));
         1: c = 8'("A" + $urandom_range(25));
         2: c = 8'("0" + $urandom_range(9));
         default: c = punct[$urandom_range(4)];
      endcase
      return c;
   endfunction

   function automatic void add_text(string s);
      int k;
      for (k = 0; k < s.len(); k++)
         line_q.push_back(s[k]);
   endfunction

   function automatic void add_filler(int n);
      repeat (n) line_q.push_back(path_char());
   endfunction

   function automatic void add_http_marker();
      string word;
      int    k;
      word = "HTTP";
      for (k = 0; k < 4; k++)
         line_q.push_back(word[k] ^ ($urandom_range(1) ? 8'h20 : 8'h00));
      line_q.push_back(CHAR_SLASH);
   endfunction

   function automatic void add_pattern_segment(int slot);
      int len, start, k;
      len = status_sb.slot_len(slot);
      start = line_q.size();
      for (k = 0; k < len; k++)
         line_q.push_back(status_sb.pat_text[slot][8*k +: 8]);
      if (len > 0 && $urandom_range(3) == 0)
         line_q[start + $urandom_range(len - 1)] = path_char();
      add_filler($urandom_range(0, 5));
      repeat ($urandom_range(0, 2)) line_q.push_back(CHAR_SPACE);
   endfunction

   function automatic void build_good_request();
      line_q.delete();
      add_text("POST");
      repeat (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3))
         line_q.push_back(CHAR_SPACE);
      line_q.push_back(CHAR_SLASH);
      repeat ($urandom_range(0, 2)) begin
         add_filler($urandom_range(0, 5));
         line_q.push_back(CHAR_SLASH);
      end
      if ($urandom_range(4) == 0)
         add_filler($urandom_range(0, 11));
      else
         add_pattern_segment($urandom_range(PATTERN_SLOTS - 1));
      if ($urandom_range(3) != 0)
         line_q.push_back(CHAR_SPACE);
      add_http_marker();
      add_filler($urandom_range(0, 4));
   endfunction

   function automatic void build_broken_request();
      int n;
      line_q.delete();
      case ($urandom_range(5))
         0: begin
            build_good_request();
            n = $urandom_range(1, 7);
            while (line_q.size() > n) void'(line_q.pop_back());
         end
         1: begin
            build_good_request();
            line_q[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
         end
         2: begin
            add_text("POST");
            repeat ($urandom_range(0, 2)) line_q.push_back(CHAR_SPACE);
            add_filler($urandom_range(1, 10));
         end
         3: begin
            add_text("POST");
            repeat ($urandom_range(4, 8)) line_q.push_back(CHAR_SPACE);
         end
         4: begin
            add_text("POST /");
            add_filler($urandom_range(2, 12));
            add_http_marker();
            n = line_q.size() - 1 - $urandom_range(4);
            if ($urandom_range(1))
               line_q[n] = path_char();
            else
               void'(line_q.pop_back());
         end
         default: repeat ($urandom_range(1, 24)) line_q.push_back(8'($urandom_range(255)));
      endcase
   endfunction

   task automatic offer_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_payload.request_byte <= b;
      req_payload.last_byte <= last;
      do @(posedge clock); while (req_stall);
      status_sb.note_byte(req_payload);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_line();
      int k;
      for (k = 0; k < line_q.size(); k++)
         offer_byte(line_q[k], k == line_q.size() - 1);
      requests_sent++;
   endtask

   task automatic send_text(input string s);
      line_q.delete();
      add_text(s);
      send_line();
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (status_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      status_sb.write_reg(idx, data);
   endtask

   task automatic apply_setting(input setting_kind_type kind);
      logic [63:0] text [PATTERN_SLOTS];
      logic [15:0] lens;
      logic [2:0]  count;
      int          i, k;
      case (kind)
         SET_DIRECTED: begin
            text[0] = pack_text("index");
            text[1] = pack_text("ab");
            text[2] = '1;
            text[3] = pack_text("zzz");
            lens = 16'h0F25;
            count = 3'd7;
         end
         SET_CLEAR: begin
            foreach (text[j]) text[j] = '0;
            lens = '0;
            count = '0;
         end
         SET_FULL: begin
            foreach (text[j]) text[j] = '1;
            lens = 16'hFFFF;
            count = 3'd7;
         end
         default: begin
            for (i = 0; i < PATTERN_SLOTS; i++) begin
               for (k = 0; k < 8; k++)
                  text[i][8*k +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                                : path_char();
               lens[4*i +: 4] = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                          : 4'($urandom_range(1, 6));
            end
            if ($urandom_range(1))
               text[2] = text[0];
            count = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                             : 3'($urandom_range(1, 4));
         end
      endcase
      csr_write(CSR_PATTERN_TEXT_0, text[0]);
      csr_write(CSR_PATTERN_TEXT_1, text[1]);
      csr_write(CSR_PATTERN_TEXT_2, text[2]);
      csr_write(CSR_PATTERN_TEXT_3, text[3]);
      csr_write(CSR_PATTERN_LENGTHS, {48'($urandom), lens});
      csr_write(CSR_PATTERN_COUNT, {61'($urandom), count});
      if (kind == SET_DIRECTED || $urandom_range(2) == 0) begin
         csr_write(CSR_SPARE_6, {$urandom, $urandom});
         csr_write(CSR_SPARE_7, {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   initial begin : stimulus
      int ph;
      int phase_start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_setting(SET_DIRECTED);
      send_text("POST /index HTTP/1.1");
      send_text("POST /x/ab  HTTP/1.1");
      send_text("POST /abc/zz hTtP/");
      send_text("POST /ind HTTP/");
      send_text("POST/indexes/ HTTP/");
      send_text("POST /HTTP/");
      line_q.delete();
      add_text("POST /");
      repeat (8) line_q.push_back(8'hFF);
      add_text(" HTTP/");
      send_line();
      send_text("POST /");
      send_text("POST /a");
      send_text("GET / HTTP/1.1");
      send_text("post /index HTTP/1.1");
      send_text("POST   x HTTP/1.1");
      send_text("POST    ");
      send_text("POST /index HTTP 1.1");
      send_text("POST /index HTTP");
      send_text("POST /indexing HTTP/ HTTP/ junk");
      send_text("/");

      for (ph = 0; ph < PHASES; ph++) begin
         wait_drain();
         case (ph)
            0: apply_setting(SET_CLEAR);
            1: apply_setting(SET_FULL);
            default: apply_setting(SET_RANDOM);
         endcase
         case (ph % 3)
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 16;
         endcase
         case (ph % 4)
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 80;
         endcase
         // back up the result side and keep offering bytes
         if (ph == 4) begin
            gap_max = 0;
            hold_request = 1'b1;
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
            if ($urandom_range(9) < 7)
               build_good_request();
            else
               build_broken_request();
            send_line();
         end
      end
      wait_drain();

      $display("Covered %0d requests, %0d bytes, %0d register settings",
               requests_sent, bytes_sent, settings_applied);
      $display({"Statuses: matched %0d, short %0d, not POST %0d, no slash %0d, ",
                "no HTTP %0d, no pattern %0d"},
               status_sb.status_seen[ST_MATCHED], status_sb.status_seen[ST_SHORT],
               status_sb.status_seen[ST_NOT_POST], status_sb.status_seen[ST_NO_SLASH],
               status_sb.status_seen[ST_NO_HTTP], status_sb.status_seen[ST_NO_PATTERN]);
      if (status_sb.failures == 0 && status_sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/prlm_pkg.sv
rtl/prlm_front.sv
rtl/prlm_fifo.sv
rtl/prlm_back.sv
rtl/post_request_line_matcher_top.sv
tb/post_request_line_matcher_top_tb.sv
